### sv/tcw_pkg.sv
// shared command codes, character and attribute constants for the text console writer
package tcw_pkg;

  localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
  localparam logic [2:0] CMD_BACKSPACE  = 3'd1;
  localparam logic [2:0] CMD_CLEAR      = 3'd2;
  localparam logic [2:0] CMD_SET_PLACE  = 3'd3;
  localparam logic [2:0] CMD_PLACE_CHAR = 3'd4;
  localparam logic [2:0] CMD_READ_CELL  = 3'd5;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

endpackage

### sv/text_console_writer_unit.sv
// text console writer: cell store, cursor, scroll and clear sequencer
//
//   channel   direction  handshake                 payload
//   command   in         in_valid_i / in_ready_o   cmd_i ch_i color_i col_i row_i
//   result    out        out_valid_o / out_ready_i cursor_col_o cursor_row_o hw_cursor_o
//                                                  cell_char_o cell_attr_o
//   config    in         cfg_we_i                  cfg_wdata_i (blank attribute)
//
// a command runs as accept (store write or read issue), then result load.
// scrolling adds a row copy through the registered read port, then blanking of the
// bottom row; clear adds a sweep of one blank write per cell over the whole store.
// after reset the store is swept to spaces with the reset attribute before the first
// command is taken; the blank attribute register can be written meanwhile.
// a result waits in its state until the output register is free; the output register
// lets the next command be taken while the previous result is still pending.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  ch_i,
  input  logic [7:0]  color_i,
  input  logic [6:0]  col_i,
  input  logic [4:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] hw_cursor_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o
);

  localparam int unsigned NCELLS = COLS * ROWS;
  localparam int unsigned CW     = $clog2(COLS);
  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned PTR_W  = $clog2(NCELLS + 1);
  localparam int unsigned RAW_W  = $clog2(32 * COLS + 128);

  localparam logic [CW-1:0]    COL_LAST   = CW'(COLS - 1);
  localparam logic [RW-1:0]    ROW_LAST   = RW'(ROWS - 1);
  localparam logic [AW-1:0]    COLS_A     = AW'(COLS);
  localparam logic [AW-1:0]    CELL_LAST  = AW'(NCELLS - 1);
  localparam logic [AW-1:0]    LAST_ROW_0 = AW'(NCELLS - COLS);
  localparam logic [RAW_W-1:0] COLS_R     = RAW_W'(COLS);
  localparam logic [PTR_W-1:0] PTR_END    = PTR_W'(NCELLS);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RESULT = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_BLANK  = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  // cell store, {char, attr}
  logic [15:0] mem [NCELLS];
  logic [15:0] mem_rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    cur_col_q, cur_col_d;
  logic [RW-1:0]    cur_row_q, cur_row_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [AW-1:0]    hw_q, hw_d;
  logic [7:0]       blank_attr_q;
  logic             rd_ok_q, rd_ok_d;

  logic        out_valid_q, out_valid_d;
  logic [6:0]  out_col_q, out_col_d;
  logic [4:0]  out_row_q, out_row_d;
  logic [10:0] out_hw_q, out_hw_d;
  logic [7:0]  out_char_q, out_char_d;
  logic [7:0]  out_attr_q, out_attr_d;

  logic [15:0]      blank_cell;
  logic [7:0]       attr_sel;
  logic [AW-1:0]    cur_pos, nxt_pos;
  logic [RAW_W-1:0] raw_pos;
  logic             in_rng;
  logic             hw_upd, bs_wr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign blank_cell = {SPACE_CHAR, blank_attr_q};
  assign attr_sel   = (color_i != 8'd0) ? color_i : blank_attr_q;
  assign cur_pos    = AW'(cur_row_q) * COLS_A + AW'(cur_col_q);
  assign raw_pos    = RAW_W'(row_i) * COLS_R + RAW_W'(col_i);
  assign in_rng     = (32'(col_i) < COLS) && (32'(row_i) < ROWS);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    ptr_d       = ptr_q;
    hw_d        = hw_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_hw_d    = out_hw_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = '0;
    hw_upd      = 1'b0;
    bs_wr       = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = {SPACE_CHAR, RESET_ATTR};
        if (idx_q == CELL_LAST) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_ok_d = 1'b0;
          state_d = ST_RESULT;
          case (cmd_i)
            CMD_PUT_CHAR: begin
              hw_upd = 1'b1;
              if (ch_i != NEWLINE_CHAR) begin
                mem_we    = 1'b1;
                mem_waddr = cur_pos;
                mem_wdata = {ch_i, attr_sel};
              end
              if (ch_i == NEWLINE_CHAR || cur_col_q == COL_LAST) begin
                cur_col_d = '0;
                if (cur_row_q == ROW_LAST) begin
                  // bottom row: scroll, cursor stays on the last row
                  idx_d   = '0;
                  state_d = ST_COPY;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                end
              end else begin
                cur_col_d = cur_col_q + 1'b1;
              end
            end
            CMD_BACKSPACE: begin
              if (cur_col_q != '0) begin
                cur_col_d = cur_col_q - 1'b1;
                hw_upd    = 1'b1;
                bs_wr     = 1'b1;
              end else if (cur_row_q != '0) begin
                cur_row_d = cur_row_q - 1'b1;
                cur_col_d = COL_LAST;
                hw_upd    = 1'b1;
                bs_wr     = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cur_col_d = '0;
              cur_row_d = '0;
              idx_d     = '0;
              state_d   = ST_CLEAR;
            end
            CMD_SET_PLACE: begin
              ptr_d = (32'(raw_pos) < NCELLS) ? PTR_W'(raw_pos) : PTR_END;
              if (in_rng) begin
                cur_col_d = CW'(col_i);
                cur_row_d = RW'(row_i);
              end
            end
            CMD_PLACE_CHAR: begin
              if (ptr_q < PTR_END) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ptr_q);
                mem_wdata = {ch_i, attr_sel};
                ptr_d     = ptr_q + 1'b1;
              end
            end
            CMD_READ_CELL: begin
              if (in_rng) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(raw_pos);
                rd_ok_d   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_COPY: begin
        // read row below through the read register, written to the row above in the next cycle
        if (idx_q != LAST_ROW_0) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + COLS_A;
        end
        if (idx_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q - 1'b1;
          mem_wdata = mem_rdata_q;
        end
        if (idx_q == LAST_ROW_0) begin
          state_d = ST_BLANK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_BLANK, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = blank_cell;
        if (idx_q == CELL_LAST) begin
          idx_d   = '0;
          state_d = ST_RESULT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_col_d   = 7'(cur_col_q);
          out_row_d   = 5'(cur_row_q);
          out_hw_d    = 11'(hw_q);
          out_char_d  = rd_ok_q ? mem_rdata_q[15:8] : 8'd0;
          out_attr_d  = rd_ok_q ? mem_rdata_q[7:0] : 8'd0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // position of the updated cursor, for the hardware cursor and backspace blanking
    nxt_pos = AW'(cur_row_d) * COLS_A + AW'(cur_col_d);
    if (hw_upd) begin
      hw_d = nxt_pos;
    end
    if (bs_wr) begin
      mem_we    = 1'b1;
      mem_waddr = nxt_pos;
      mem_wdata = blank_cell;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      idx_q        <= '0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      ptr_q        <= '0;
      hw_q         <= '0;
      blank_attr_q <= RESET_ATTR;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      ptr_q       <= ptr_d;
      hw_q        <= hw_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        blank_attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_hw_q   <= out_hw_d;
    out_char_q <= out_char_d;
    out_attr_q <= out_attr_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign hw_cursor_o  = out_hw_q;
  assign cell_char_o  = out_char_q;
  assign cell_attr_o  = out_attr_q;

endmodule

### tb/tcw_checker.sv
// console state predictor and result checker for the text console writer
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  ch_i,
  input  logic [7:0]  color_i,
  input  logic [6:0]  col_i,
  input  logic [4:0]  row_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0]  cursor_col_i,
  input  logic [4:0]  cursor_row_i,
  input  logic [10:0] hw_cursor_i,
  input  logic [7:0]  cell_char_i,
  input  logic [7:0]  cell_attr_i,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] hw_cursor;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } console_view_t;

  logic [7:0]    scr_char [CELLS];
  logic [7:0]    scr_attr [CELLS];
  int unsigned   cur_c;
  int unsigned   cur_r;
  int unsigned   place_ptr;
  int unsigned   hw_pos;
  logic [7:0]    blank_attr;
  console_view_t pending_views [$];
  int unsigned   mismatch_cnt;

  function automatic void blank_cells(int unsigned first, int unsigned last);
    for (int unsigned i = first; i < last && i < CELLS; i++) begin
      scr_char[i] = SPACE_CHAR;
      scr_attr[i] = blank_attr;
    end
  endfunction

  function automatic void reset_console();
    blank_attr = RESET_ATTR;
    blank_cells(0, CELLS);
    cur_c = 0;
    cur_r = 0;
    place_ptr = 0;
    hw_pos = 0;
  endfunction

  // moving past the bottom row shifts everything up and blanks the last row
  function automatic void next_line();
    cur_c = 0;
    cur_r++;
    if (cur_r >= ROWS) begin
      for (int unsigned i = 0; i + COLS < CELLS; i++) begin
        scr_char[i] = scr_char[i + COLS];
        scr_attr[i] = scr_attr[i + COLS];
      end
      blank_cells(CELLS - COLS, CELLS);
      cur_r = ROWS - 1;
    end
  endfunction

  function automatic console_view_t apply_console_cmd(logic [2:0] cmd, logic [7:0] ch,
                                                     logic [7:0] color, logic [6:0] col,
                                                     logic [4:0] row);
    console_view_t view;
    logic [7:0]    attr;
    int unsigned   pos;
    view = '0;
    attr = (color != 8'h00) ? color : blank_attr;
    case (cmd)
      CMD_PUT_CHAR: begin
        if (ch == NEWLINE_CHAR) begin
          next_line();
        end else begin
          pos = cur_r * COLS + cur_c;
          if (pos < CELLS) begin
            scr_char[pos] = ch;
            scr_attr[pos] = attr;
          end
          cur_c++;
          if (cur_c >= COLS) next_line();
        end
        hw_pos = cur_r * COLS + cur_c;
      end
      CMD_BACKSPACE: begin
        // at the origin nothing moves and the hardware cursor stays
        if (cur_c > 0 || cur_r > 0) begin
          if (cur_c > 0) begin
            cur_c--;
          end else begin
            cur_r--;
            cur_c = COLS - 1;
          end
          pos = cur_r * COLS + cur_c;
          blank_cells(pos, pos + 1);
          hw_pos = pos;
        end
      end
      CMD_CLEAR: begin
        blank_cells(0, CELLS);
        cur_c = 0;
        cur_r = 0;
      end
      CMD_SET_PLACE: begin
        pos = row * COLS + col;
        place_ptr = (pos < CELLS) ? pos : CELLS;
        if (col < COLS && row < ROWS) begin
          cur_c = col;
          cur_r = row;
        end
      end
      CMD_PLACE_CHAR: begin
        if (place_ptr < CELLS) begin
          scr_char[place_ptr] = ch;
          scr_attr[place_ptr] = attr;
          place_ptr++;
        end
      end
      CMD_READ_CELL: begin
        if (col < COLS && row < ROWS) begin
          pos = row * COLS + col;
          view.cell_char = scr_char[pos];
          view.cell_attr = scr_attr[pos];
        end
      end
      default: begin
      end
    endcase
    view.cursor_col = 7'(cur_c);
    view.cursor_row = 5'(cur_r);
    view.hw_cursor  = 11'(hw_pos);
    return view;
  endfunction

  always @(posedge clk_i) begin
    console_view_t want;
    if (!rst_ni) begin
      reset_console();
      pending_views.delete();
      mismatch_cnt = 0;
    end else begin
      if (cfg_we_i) blank_attr = cfg_wdata_i;
      // results first: a command taken at this edge cannot have its result out yet
      if (out_valid_i && out_ready_i) begin
        if (pending_views.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("%0t: unexpected result transaction col=%0d row=%0d hw=%0d",
                     $realtime, cursor_col_i, cursor_row_i, hw_cursor_i);
          mismatch_cnt++;
        end else begin
          want = pending_views.pop_front();
          if (cursor_col_i != want.cursor_col || cursor_row_i != want.cursor_row ||
              hw_cursor_i != want.hw_cursor || cell_char_i != want.cell_char ||
              cell_attr_i != want.cell_attr) begin
            if (mismatch_cnt < MAX_REPORTS) begin
              $display("%0t: mismatch: exp col=%0d row=%0d hw=%0d char=%02h attr=%02h",
                       $realtime, want.cursor_col, want.cursor_row, want.hw_cursor,
                       want.cell_char, want.cell_attr);
              $display("%0t: got col=%0d row=%0d hw=%0d char=%02h attr=%02h",
                       $realtime, cursor_col_i, cursor_row_i, hw_cursor_i,
                       cell_char_i, cell_attr_i);
            end
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pending_views.push_back(apply_console_cmd(cmd_i, ch_i, color_i, col_i, row_i));
    end
    // anything still waiting counts against the run as well
    fail_count_o <= mismatch_cnt + pending_views.size();
  end

endmodule

### tb/tb.sv
// testbench top for the text console writer: stimulus, flow control and verdict
module tb
  import tcw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCREEN_COLS    = 80;
  localparam int unsigned SCREEN_ROWS    = 25;
  localparam int unsigned ITEMS          = 1300;
  localparam int unsigned CALM_TAIL      = 200;
  localparam int unsigned HOLD_AT        = 500;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 16;

  // command codes with no function
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i = CMD_PUT_CHAR;
  logic [7:0]  ch_i = 8'h00;
  logic [7:0]  color_i = 8'h00;
  logic [6:0]  col_i = 7'd0;
  logic [4:0]  row_i = 5'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [10:0] hw_cursor_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attr_o;

  int unsigned fail_count;
  int unsigned sent = 0;
  int unsigned out_count = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  text_console_writer_unit #(
    .COLS(SCREEN_COLS),
    .ROWS(SCREEN_ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .ch_i         (ch_i),
    .color_i      (color_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .hw_cursor_o  (hw_cursor_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o)
  );

  tcw_checker #(
    .COLS(SCREEN_COLS),
    .ROWS(SCREEN_ROWS)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .cmd_i        (cmd_i),
    .ch_i         (ch_i),
    .color_i      (color_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cursor_col_i (cursor_col_o),
    .cursor_row_i (cursor_row_o),
    .hw_cursor_i  (hw_cursor_o),
    .cell_char_i  (cell_char_o),
    .cell_attr_i  (cell_attr_o),
    .fail_count_o (fail_count)
  );

  // result count and watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) out_count <= out_count + 1;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("text_console_writer_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off mid run, steady at the end
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (sent + CALM_TAIL < ITEMS && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(40, 150)) @(posedge clk_i);
        else repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] pick_color();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                          input logic [7:0] color, input logic [6:0] col,
                          input logic [4:0] row);
    if (sent + CALM_TAIL < ITEMS && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    ch_i       <= ch;
    color_i    <= color;
    col_i      <= col;
    row_i      <= row;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (out_count != sent) @(posedge clk_i);
  endtask

  task automatic write_blank_attr(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned phase;
    logic [6:0]  col;
    logic [4:0]  row;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads at the corners, backspace at origin, wrap and scroll,
    // saturated place pointer, dropped place writes, unused codes, clear
    send_cmd(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_READ_CELL, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_cmd(CMD_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd24);
    send_cmd(CMD_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_PUT_CHAR, 8'h41, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_PUT_CHAR, 8'hFF, 8'hFF, 7'd0, 5'd0);
    send_cmd(CMD_PUT_CHAR, 8'h00, 8'h01, 7'd0, 5'd0);
    send_cmd(CMD_PUT_CHAR, NEWLINE_CHAR, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_SET_PLACE, 8'h00, 8'h00, 7'd79, 5'd24);
    send_cmd(CMD_PUT_CHAR, 8'h5A, 8'h0E, 7'd0, 5'd0);
    send_cmd(CMD_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd23);
    send_cmd(CMD_PUT_CHAR, NEWLINE_CHAR, 8'h0F, 7'd0, 5'd0);
    send_cmd(CMD_SET_PLACE, 8'h00, 8'h00, 7'd0, 5'd25);
    send_cmd(CMD_PLACE_CHAR, 8'h71, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_SET_PLACE, 8'h00, 8'h00, 7'd78, 5'd24);
    send_cmd(CMD_PLACE_CHAR, NEWLINE_CHAR, 8'h33, 7'd0, 5'd0);
    send_cmd(CMD_PLACE_CHAR, 8'h72, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_PLACE_CHAR, 8'h73, 8'h44, 7'd0, 5'd0);
    send_cmd(CMD_READ_CELL, 8'h00, 8'h00, 7'd78, 5'd24);
    send_cmd(CMD_SET_PLACE, 8'h00, 8'h00, 7'd127, 5'd0);
    send_cmd(CMD_PLACE_CHAR, 8'h70, 8'h80, 7'd0, 5'd0);
    send_cmd(CMD_SPARE_A, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
    send_cmd(CMD_SPARE_B, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
    send_cmd(CMD_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_READ_CELL, 8'h00, 8'h00, 7'd1, 5'd1);

    settle();
    write_blank_attr(8'h00);
    phase = 0;

    while (sent < ITEMS) begin
      if (phase < 3 && sent >= 350 + phase * 300) begin
        settle();
        case (phase)
          0:       write_blank_attr(8'hFF);
          default: write_blank_attr(8'($urandom_range(1, 254)));
        endcase
        phase++;
      end
      k = $urandom_range(0, 99);
      if (k < 45) begin
        // a run of text with line breaks and the odd correction
        n = $urandom_range(8, 40);
        repeat (n) begin
          k = $urandom_range(0, 29);
          if (k < 3)
            send_cmd(CMD_PUT_CHAR, NEWLINE_CHAR, pick_color(), 7'($urandom), 5'($urandom));
          else if (k < 5)
            send_cmd(CMD_BACKSPACE, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
          else
            send_cmd(CMD_PUT_CHAR, 8'($urandom), pick_color(), 7'($urandom), 5'($urandom));
        end
      end else if (k < 70) begin
        // positioned string, then read part of it back
        k = $urandom_range(0, 7);
        if (k == 0) begin
          col = 7'($urandom_range(0, 127));
          row = 5'($urandom_range(25, 31));
        end else if (k == 1) begin
          col = 7'($urandom_range(80, 127));
          row = 5'($urandom_range(0, 31));
        end else if (k == 2) begin
          col = 7'($urandom_range(70, 79));
          row = 5'd24;
        end else begin
          col = 7'($urandom_range(0, 79));
          row = 5'($urandom_range(0, 24));
        end
        send_cmd(CMD_SET_PLACE, 8'($urandom), 8'($urandom), col, row);
        n = $urandom_range(1, 16);
        repeat (n)
          send_cmd(CMD_PLACE_CHAR, 8'($urandom), pick_color(), 7'($urandom), 5'($urandom));
        n = $urandom_range(1, 4);
        for (int unsigned j = 0; j < n; j++)
          send_cmd(CMD_READ_CELL, 8'($urandom), 8'($urandom), 7'((col + j) % 80), row);
      end else if (k < 82) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0)
            send_cmd(CMD_READ_CELL, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
          else
            send_cmd(CMD_READ_CELL, 8'($urandom), 8'($urandom),
                     7'($urandom_range(0, 79)), 5'($urandom_range(0, 24)));
        end
      end else if (k < 85) begin
        send_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
      end else begin
        // noise: any code, any field value
        n = $urandom_range(1, 6);
        repeat (n)
          send_cmd(3'($urandom), 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_console_writer_unit test passed");
    end else begin
      $display("text_console_writer_unit test failed");
    end
    $finish;
  end

endmodule
